>>> rtl/core/tps_pkg.sv
// tone pattern sequencer package: sizes, command codes, payload structs
// and the control/status structs shared by the controller and datapath
// no dependencies

package tps_pkg;

  // table geometry
  localparam int MaxEntries = 8;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CountW     = $clog2(MaxEntries + 1);
  localparam logic [CountW-1:0] MaxCount = CountW'(MaxEntries);

  // field widths
  localparam int CmdW   = 2;
  localparam int FreqW  = 16;
  localparam int TicksW = 16;
  localparam int ClkW   = 20;
  localparam int DivW   = 8;

  localparam logic [ClkW-1:0] ToneClockReset = ClkW'(31250);
  localparam logic [DivW-1:0] DivSat         = {DivW{1'b1}};

  // serial divider: one quotient bit per step
  localparam int DivSteps = ClkW;
  localparam int DivCntW  = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DivSteps - 1);

  // command codes
  typedef enum logic [CmdW-1:0] {
    CmdTick  = 2'd0,
    CmdWrite = 2'd1,
    CmdStart = 2'd2,
    CmdNop   = 2'd3
  } cmd_e;

  // input transaction
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [2:0]        entry_index;
    logic [FreqW-1:0]  tone_freq;
    logic [TicksW-1:0] audible_ticks;
    logic [TicksW-1:0] silent_ticks;
    logic [3:0]        entry_count;
  } item_t;

  // result transaction
  typedef struct packed {
    logic            tone_on;
    logic [DivW-1:0] tone_divider;
    logic            tone_restart;
    logic            busy_res;
  } result_t;

  // one table entry
  typedef struct packed {
    logic [FreqW-1:0]  freq;
    logic [TicksW-1:0] audible;
    logic [TicksW-1:0] silent;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic div_load;
    logic div_step;
    logic div_wb;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_last;
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StDivLoad,
    StDivRun,
    StDivWb,
    StResp
  } state_e;

endpackage

>>> rtl/core/tps_ctrl.sv
// tone pattern sequencer controller: sequences latch, execute, divide (only
// when the datapath needs it) and respond for each transaction
// depends on tps_pkg

module tps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  tps_pkg::status_t status_i,
  output tps_pkg::ctrl_t   ctrl_o,
  output logic             busy,
  output logic             result_valid_o
);

  tps_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tps_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tps_pkg::StIdle: begin
        if (start) state_d = tps_pkg::StExec;
      end
      tps_pkg::StExec: begin
        state_d = status_i.div_needed ? tps_pkg::StDivLoad : tps_pkg::StResp;
      end
      tps_pkg::StDivLoad: begin
        state_d = tps_pkg::StDivRun;
      end
      tps_pkg::StDivRun: begin
        if (status_i.div_last) state_d = tps_pkg::StDivWb;
      end
      tps_pkg::StDivWb: begin
        state_d = tps_pkg::StResp;
      end
      tps_pkg::StResp: begin
        state_d = tps_pkg::StIdle;
      end
      default: begin
        state_d = tps_pkg::StIdle;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o         = '0;
    busy           = (state_q != tps_pkg::StIdle);
    result_valid_o = 1'b0;
    unique case (state_q)
      tps_pkg::StIdle:    ctrl_o.latch    = start;
      tps_pkg::StExec:    ctrl_o.exec     = 1'b1;
      tps_pkg::StDivLoad: ctrl_o.div_load = 1'b1;
      tps_pkg::StDivRun:  ctrl_o.div_step = 1'b1;
      tps_pkg::StDivWb:   ctrl_o.div_wb   = 1'b1;
      tps_pkg::StResp:    result_valid_o  = 1'b1;
      default:            ctrl_o          = '0;
    endcase
  end

`ifndef SYNTHESIS
  // a response always returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tps_pkg::StResp) |=> (state_q == tps_pkg::StIdle))
    else $error("controller did not return to idle after response");

  // the divider only runs after a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ctrl_o.div_step) |-> $past(ctrl_o.div_load))
    else $error("divider stepped without load");

  // an accepted command is always executed next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.latch |=> ctrl_o.exec)
    else $error("latched command not executed");
`endif

endmodule

>>> rtl/core/tps_datapath.sv
// tone pattern sequencer datapath: tone table, playback state, tick timer
// and the restoring serial divider for the tone divider value
// depends on tps_pkg

module tps_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tps_pkg::ClkW-1:0]     cfg_wdata_i,
  input  tps_pkg::item_t               item_i,
  input  tps_pkg::ctrl_t               ctrl_i,
  output tps_pkg::status_t             status_o,
  output tps_pkg::result_t             result_o
);

  // tone table, undefined until written
  tps_pkg::entry_t table_q [tps_pkg::MaxEntries];

  tps_pkg::item_t item_q;

  logic [tps_pkg::ClkW-1:0]   tone_clock_q;
  logic [tps_pkg::CountW-1:0] play_count_q, play_count_d;
  logic [tps_pkg::CountW-1:0] play_index_q, play_index_d;
  logic                       playing_q, playing_d;
  logic                       start_pending_q, start_pending_d;
  logic [tps_pkg::TicksW-1:0] tick_timer_q, tick_timer_d;
  logic                       in_audible_q, in_audible_d;
  logic [tps_pkg::DivW-1:0]   divider_q;
  logic                       restart_q, restart_d;

  // divider registers
  logic [tps_pkg::FreqW-1:0]   rem_q;
  logic [tps_pkg::ClkW-1:0]    quo_q;
  logic [tps_pkg::FreqW-1:0]   den_q;
  logic [tps_pkg::DivCntW-1:0] div_cnt_q;

  tps_pkg::entry_t            cur_entry;
  logic                       need_div;
  logic                       begin_req;
  logic [tps_pkg::CountW-1:0] begin_idx;
  logic [tps_pkg::TicksW:0]   next_cnt;
  logic [tps_pkg::FreqW:0]    shifted;
  logic                       q_bit;

  assign cur_entry = table_q[play_index_q[tps_pkg::IdxW-1:0]];
  assign next_cnt  = {1'b0, tick_timer_q} + {{tps_pkg::TicksW{1'b0}}, 1'b1};

  // command latch and table writes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) item_q <= item_i;
    if (ctrl_i.exec && (tps_pkg::cmd_e'(item_q.cmd) == tps_pkg::CmdWrite)) begin
      table_q[item_q.entry_index] <= '{freq:    item_q.tone_freq,
                                       audible: item_q.audible_ticks,
                                       silent:  item_q.silent_ticks};
    end
  end

  // command execution: tick sequencing, start and entry begin
  always_comb begin
    play_count_d    = play_count_q;
    play_index_d    = play_index_q;
    playing_d       = playing_q;
    start_pending_d = start_pending_q;
    tick_timer_d    = tick_timer_q;
    in_audible_d    = in_audible_q;
    restart_d       = restart_q;
    need_div        = 1'b0;
    begin_req       = 1'b0;
    begin_idx       = '0;
    if (ctrl_i.exec) begin
      restart_d = 1'b0;
      unique case (tps_pkg::cmd_e'(item_q.cmd))
        tps_pkg::CmdTick: begin
          priority if (start_pending_q) begin
            start_pending_d = 1'b0;
            begin_req       = 1'b1;
            begin_idx       = '0;
          end else if (!playing_q || (play_count_q == '0) ||
                       (play_index_q >= tps_pkg::MaxCount)) begin
            // idle tick, nothing changes
          end else if (in_audible_q) begin
            if (next_cnt > {1'b0, cur_entry.audible}) begin
              if (cur_entry.silent != '0) begin
                in_audible_d = 1'b0;
                tick_timer_d = '0;
              end else begin
                begin_req = 1'b1;
                begin_idx = play_index_q + tps_pkg::CountW'(1);
              end
            end else begin
              tick_timer_d = next_cnt[tps_pkg::TicksW-1:0];
            end
          end else begin
            if (next_cnt > {1'b0, cur_entry.silent}) begin
              begin_req = 1'b1;
              begin_idx = play_index_q + tps_pkg::CountW'(1);
            end else begin
              tick_timer_d = next_cnt[tps_pkg::TicksW-1:0];
            end
          end
        end
        tps_pkg::CmdWrite: begin
          // table write handled in the clocked block
        end
        tps_pkg::CmdStart: begin
          play_count_d    = (item_q.entry_count > tps_pkg::MaxCount) ?
                            tps_pkg::MaxCount : item_q.entry_count;
          start_pending_d = 1'b1;
        end
        tps_pkg::CmdNop: begin
          // status only
        end
      endcase

      // begin next entry or finish the pattern
      if (begin_req) begin
        tick_timer_d = '0;
        play_index_d = begin_idx;
        if ((begin_idx < play_count_q) && (begin_idx < tps_pkg::MaxCount)) begin
          in_audible_d = 1'b1;
          playing_d    = 1'b1;
          restart_d    = 1'b1;
          need_div     = 1'b1;
        end else begin
          playing_d    = 1'b0;
          in_audible_d = 1'b0;
          play_count_d = '0;
          play_index_d = '0;
        end
      end
    end
  end

  // playback state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_clock_q    <= tps_pkg::ToneClockReset;
      play_count_q    <= '0;
      play_index_q    <= '0;
      playing_q       <= 1'b0;
      start_pending_q <= 1'b0;
      tick_timer_q    <= '0;
      in_audible_q    <= 1'b0;
      restart_q       <= 1'b0;
      divider_q       <= '0;
    end else begin
      if (cfg_we_i) tone_clock_q <= cfg_wdata_i;
      play_count_q    <= play_count_d;
      play_index_q    <= play_index_d;
      playing_q       <= playing_d;
      start_pending_q <= start_pending_d;
      tick_timer_q    <= tick_timer_d;
      in_audible_q    <= in_audible_d;
      restart_q       <= restart_d;
      // saturate the quotient; a zero frequency gives all ones and saturates
      if (ctrl_i.div_wb) begin
        divider_q <= (quo_q[tps_pkg::ClkW-1:tps_pkg::DivW] != '0) ?
                     tps_pkg::DivSat : quo_q[tps_pkg::DivW-1:0];
      end
    end
  end

  // restoring divider step: one quotient bit per cycle while div_step is high
  assign shifted = {rem_q, quo_q[tps_pkg::ClkW-1]};
  assign q_bit   = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      rem_q     <= '0;
      quo_q     <= tone_clock_q;
      den_q     <= cur_entry.freq;
      div_cnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q     <= q_bit ? tps_pkg::FreqW'(shifted - {1'b0, den_q}) :
                           shifted[tps_pkg::FreqW-1:0];
      quo_q     <= {quo_q[tps_pkg::ClkW-2:0], q_bit};
      div_cnt_q <= div_cnt_q + tps_pkg::DivCntW'(1);
    end
  end

  // status to the controller
  assign status_o.div_needed = need_div;
  assign status_o.div_last   = (div_cnt_q == tps_pkg::DivLastStep);

  // result fields
  assign result_o.tone_on      = playing_q & in_audible_q;
  assign result_o.tone_divider = divider_q;
  assign result_o.tone_restart = restart_q;
  assign result_o.busy_res     = start_pending_q | playing_q;

endmodule

>>> rtl/core/tone_pattern_sequencer_top.sv
// tone pattern sequencer top level: joins the controller and datapath
// depends on tps_pkg, tps_ctrl, tps_datapath

// A command transaction is taken when start is high and busy is low, and
// exactly one result follows, shown for a single cycle with result_valid_o;
// the receiver cannot stall it. Writes, starts, no-op commands and ticks that
// do not begin a new table entry pass through the execute and respond states;
// a tick that begins a new entry also loads, runs and writes back the 20-step
// restoring divider for tone_clock_hz / tone_freq between those two states.
// Busy stays high until the result is shown. The tone clock register may be
// written only while busy is low.

module tone_pattern_sequencer_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [tps_pkg::ClkW-1:0] cfg_wdata_i,
  input  logic                     start,
  output logic                     busy,
  input  tps_pkg::item_t           item_i,
  output logic                     result_valid_o,
  output tps_pkg::result_t         result_o
);

  tps_pkg::ctrl_t   ctrl;
  tps_pkg::status_t status;

  // sequencing controller
  tps_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .status_i       (status),
    .ctrl_o         (ctrl),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  // table, playback state and divider
  tps_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .result_o    (result_o)
  );

`ifndef SYNTHESIS
  // an accepted transaction keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  // results are single-cycle strobes inside a busy window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside busy window");

  // a restarted entry always starts in its audible part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.tone_restart) |-> result_o.tone_on)
    else $error("restart without tone on");

  // tone on implies playback is active
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.tone_on) |-> result_o.busy_res)
    else $error("tone on while not busy");
`endif

endmodule
